### rtl/scap_pkg.sv
// Shared types and constants for the serial A/D converter port pair.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scap_pkg;

   localparam logic [7:0] OUT_MASK   = 8'hC0;
   localparam logic [7:0] OUT0_MASK  = 8'h80;
   localparam logic [7:0] OUT1_MASK  = 8'h40;
   localparam logic [7:0] CS_MASK    = 8'h10;
   localparam logic [7:0] SEL_MASK   = 8'h0C;
   localparam logic [7:0] CLK_MASK   = 8'h01;
   localparam logic [7:0] SERIAL_HI  = 8'hFE;
   localparam logic [7:0] READBACK_HI = 8'hFC;
   localparam logic [7:0] IDLE_BYTE  = 8'hFF;
   localparam logic [7:0] WRITTEN_RESET = 8'hFF;
   localparam logic [3:0] LOAD_CNT   = 4'd12;
   localparam logic [3:0] START_CNT  = 4'd10;
   localparam logic [3:0] DATA_LAST  = 4'd2;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct packed {
      logic       func;
      logic       port_odd;
      logic [7:0] write_data;
      logic [7:0] light_sample;
      logic [7:0] temp_sample;
      logic [7:0] sound_sample;
      logic [7:0] spare_sample;
   } scap_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out0_event;
      logic       out0_on;
      logic       out1_event;
      logic       out1_on;
   } scap_rsp_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } scap_flow_type;

endpackage

`default_nettype wire

### rtl/scap_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on scap_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scap_req_if;
   import scap_pkg::*;
   logic         valid;
   logic         ready;
   scap_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface scap_rsp_if;
   import scap_pkg::*;
   logic         valid;
   logic         ready;
   scap_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/scap_in_stage.sv
// Input register for request transactions; issues the advance strobe.
// Depends on scap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scap_in_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire scap_pkg::scap_req_type req_payload,
   input  wire logic                   out_space,
   output scap_pkg::scap_flow_type     flow,
   output scap_pkg::scap_req_type      item
);
   import scap_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   scap_req_type item_ff;
   logic         advance;
   logic         take;

   assign advance   = valid_ff & out_space;
   assign req_ready = ~valid_ff | advance;
   assign take      = req_valid & req_ready;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_payload;
      end
   end

   assign flow.valid   = valid_ff;
   assign flow.advance = advance;
   assign item         = item_ff;

endmodule

`default_nettype wire

### rtl/scap_core.sv
// Converter state (last byte, held sample, bit counter) and result logic.
// Depends on scap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scap_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire scap_pkg::scap_flow_type flow,
   input  wire scap_pkg::scap_req_type  item,
   output scap_pkg::scap_rsp_type       result
);
   import scap_pkg::*;

   logic [7:0]   written_ff;
   logic [7:0]   written_in;
   logic [7:0]   held_ff;
   logic [7:0]   held_in;
   logic [3:0]   count_ff;
   logic [3:0]   count_in;
   logic [3:0]   count_mid;
   logic [3:0]   bit_idx;
   logic [7:0]   diff;
   logic [7:0]   val;
   logic [1:0]   chan;
   logic [7:0]   chosen;
   logic         serial;
   logic         wr_even;
   logic         cs_toggle;
   logic         clk_rise;

   assign val     = item.write_data;
   assign diff    = written_ff ^ val;
   assign wr_even = (item.func == FUNC_WRITE) & ~item.port_odd;
   assign chan    = {val[2], val[3]};
   assign bit_idx = count_ff - DATA_LAST;
   assign cs_toggle = |(diff & CS_MASK);
   assign clk_rise  = |(diff & CLK_MASK) & |(val & CLK_MASK);

   always_comb begin
      unique case (chan)
         2'd0:    chosen = item.light_sample;
         2'd1:    chosen = item.temp_sample;
         2'd2:    chosen = item.sound_sample;
         default: chosen = item.spare_sample;
      endcase
   end

   always_comb begin
      priority if (count_ff == START_CNT) begin
         serial = 1'b0;
      end else if (count_ff < START_CNT && count_ff >= DATA_LAST) begin
         serial = held_ff[bit_idx[2:0]];
      end else begin
         serial = 1'b1;
      end
   end

   always_comb begin
      written_in = written_ff;
      held_in    = held_ff;
      count_mid  = count_ff;
      count_in   = count_ff;
      if (flow.advance && wr_even) begin
         written_in = val;
         if (cs_toggle) begin
            if (|(val & CS_MASK)) begin
               held_in   = chosen;
               count_mid = LOAD_CNT;
            end else begin
               count_mid = '0;
            end
         end
         count_in = count_mid;
         if (clk_rise && count_mid != '0) begin
            count_in = count_mid - 4'd1;
         end
      end
   end

   always_comb begin
      result.read_data  = IDLE_BYTE;
      result.out0_event = 1'b0;
      result.out0_on    = 1'b0;
      result.out1_event = 1'b0;
      result.out1_on    = 1'b0;
      if (item.func == FUNC_READ) begin
         if (!item.port_odd) begin
            result.read_data = SERIAL_HI | {7'd0, serial};
         end else begin
            result.read_data = READBACK_HI | {6'd0, written_ff[6], written_ff[7]};
         end
      end else if (!item.port_odd) begin
         result.out0_event = |(diff & OUT0_MASK);
         result.out1_event = |(diff & OUT1_MASK);
         result.out0_on    = ~|(val & OUT0_MASK);
         result.out1_on    = ~|(val & OUT1_MASK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= WRITTEN_RESET;
         held_ff    <= '0;
         count_ff   <= '0;
      end else begin
         written_ff <= written_in;
         held_ff    <= held_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/scap_out_stage.sv
// Result register for response transactions.
// Depends on scap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scap_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire scap_pkg::scap_flow_type flow,
   input  wire scap_pkg::scap_rsp_type  result,
   output logic                         out_space,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output scap_pkg::scap_rsp_type       rsp_payload
);
   import scap_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   scap_rsp_type data_ff;

   assign out_space = ~valid_ff | rsp_ready;
   assign valid_in  = flow.advance | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

### rtl/sensor_cartridge_serial_adc_port_core.sv
// Channel   Direction  Transaction
// req_ch    in         one bus access: kind, port, byte, four samples
// rsp_ch    out        read byte and the two output events with levels
//
// One transaction per cycle sustained while rsp_ch is ready; each transaction
// passes through the input register and then the result register.
// Synchronous active-high reset returns last byte to 0xFF, held sample and
// bit counter to 0. A stalled response holds; the input register keeps
// accepting while the result register can drain in the same cycle.
// Top level of the serial A/D converter port pair; depends on scap_pkg,
// scap_if, scap_in_stage, scap_core and scap_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module sensor_cartridge_serial_adc_port_core (
   input  wire logic clock,
   input  wire logic reset,
   scap_req_if.sink   req_ch,
   scap_rsp_if.source rsp_ch
);
   import scap_pkg::*;

   scap_flow_type flow;
   scap_req_type  item;
   scap_rsp_type  result;
   scap_rsp_type  rsp_data;
   logic          out_space;
   logic          req_rdy;
   logic          rsp_vld;

   scap_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_rdy),
      .req_payload (req_ch.payload),
      .out_space   (out_space),
      .flow        (flow),
      .item        (item)
   );

   scap_core u_core (
      .clock  (clock),
      .reset  (reset),
      .flow   (flow),
      .item   (item),
      .result (result)
   );

   scap_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .flow        (flow),
      .result      (result),
      .out_space   (out_space),
      .rsp_valid   (rsp_vld),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_data)
   );

   assign req_ch.ready   = req_rdy;
   assign rsp_ch.valid   = rsp_vld;
   assign rsp_ch.payload = rsp_data;

endmodule

`default_nettype wire

### rtl/scap_checker.sv
// Port-level checks for the serial A/D converter port pair, bound to the top.
// Depends on scap_pkg and sensor_cartridge_serial_adc_port_core.
`timescale 1ns / 1ps
`default_nettype none

module scap_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire scap_pkg::scap_rsp_type rsp_payload
);
   import scap_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_event_on_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.out0_event || rsp_payload.out1_event ||
                    rsp_payload.out0_on || rsp_payload.out1_on)
      |-> rsp_payload.read_data == IDLE_BYTE)
      else $error("output event carried read data");

   a_read_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.read_data[7:2] == 6'h3F)
      else $error("read byte upper bits not set");

endmodule

bind sensor_cartridge_serial_adc_port_core scap_checker u_scap_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire
